>>> src/timer_slot_bank_defines.svh
// Assertion macros for the timer slot bank sources.
// TSB_ASSERT checks on every clock edge outside reset.
// TSB_ASSERT_ALWAYS checks on every clock edge, reset included.
`ifndef TIMER_SLOT_BANK_DEFINES_SVH
`define TIMER_SLOT_BANK_DEFINES_SVH

`ifndef SYNTH

`define TSB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define TSB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define TSB_ASSERT(lbl, prop, msg)

`define TSB_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

>>> src/tsb_pkg.sv
package tsb_pkg;

  // Default bank size and counter width
  localparam int TSB_NUM_SLOTS   = 8;
  localparam int TSB_COUNT_WIDTH = 16;

  // Fixed field widths of the item channels
  localparam int TICKS_W = 16;
  localparam int SLOT_W  = 3;
  localparam int TIME_W  = 16;
  localparam int VEC_W   = 8;

  // Command codes
  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_ALLOC  = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

endpackage

>>> src/tsb_if.sv
// Command channel
interface tsb_cmd_if import tsb_pkg::*; ();
  logic               valid;
  logic               ready;
  op_t                operation;
  logic [TICKS_W-1:0] ticks;
  logic               periodic;
  logic [SLOT_W-1:0]  slot;

  modport source (output valid, output operation, output ticks, output periodic,
                  output slot, input ready);
  modport sink   (input valid, input operation, input ticks, input periodic,
                  input slot, output ready);
endinterface

// Response channel
interface tsb_rsp_if import tsb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] alloc_slot;
  logic              alloc_failed;
  logic [TIME_W-1:0] time_now;
  logic [VEC_W-1:0]  timeout_flags;
  logic [VEC_W-1:0]  active_flags;
  logic [VEC_W-1:0]  fired_mask;

  modport source (output valid, output alloc_slot, output alloc_failed, output time_now,
                  output timeout_flags, output active_flags, output fired_mask,
                  input ready);
  modport sink   (input valid, input alloc_slot, input alloc_failed, input time_now,
                  input timeout_flags, input active_flags, input fired_mask,
                  output ready);
endinterface

>>> src/timer_slot_bank.sv
// A tick registers the advanced counter and then scans every slot; allocate scans from
// slot 0 to the first free slot; remove and clear flag are applied when the item is taken.
// One item at a time: a single adder and deadline comparator visit one slot per cycle,
// so the bank takes no new item until the response for the last one is loaded.
// Synchronous reset clears the tick counter, active and timeout bits and the sequencer;
// deadlines and periods are not reset and are written by allocate before use.
`include "timer_slot_bank_defines.svh"

module timer_slot_bank import tsb_pkg::*; #(
  parameter int NUM_SLOTS   = TSB_NUM_SLOTS,
  parameter int COUNT_WIDTH = TSB_COUNT_WIDTH
) (
  input logic     clk,
  input logic     rst,
  tsb_cmd_if.sink   cmd,
  tsb_rsp_if.source rsp
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_TICK  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_ALLOC = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [COUNT_WIDTH-1:0] count;
  logic [COUNT_WIDTH-1:0] deadline [NUM_SLOTS];
  logic [COUNT_WIDTH-1:0] period [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]   active;
  logic [NUM_SLOTS-1:0]   timeout;
  logic [NUM_SLOTS-1:0]   fired;
  logic [IDX_W-1:0]       idx;

  // Held item
  op_t                op_q;
  logic [TICKS_W-1:0] ticks_q;
  logic               periodic_q;
  logic               alloc_fail;

  // Shared adder and deadline compare
  logic [COUNT_WIDTH-1:0] add_a, add_b, sum;
  logic [COUNT_WIDTH-1:0] ticks_c;
  logic                   hit;
  logic                   last;
  logic                   accept;
  logic                   rsp_load;
  logic                   slot_ok;
  logic [IDX_W-1:0]       slot_idx;
  logic [VEC_W-1:0]       active_vec, timeout_vec, fired_vec;

  assign accept    = cmd.valid && cmd.ready;
  assign cmd.ready = (state == S_IDLE);
  assign ticks_c   = COUNT_WIDTH'(ticks_q);
  assign last      = (idx == LAST_IDX);
  assign rsp_load  = (state == S_DONE) && (!rsp.valid || rsp.ready);
  assign slot_ok   = int'(cmd.slot) < NUM_SLOTS;
  assign slot_idx  = IDX_W'(cmd.slot);

  // Select adder operands for the current step
  always_comb begin
    add_a = count;
    add_b = COUNT_WIDTH'(1);
    unique case (state)
      S_SCAN: begin
        add_a = deadline[idx];
        add_b = period[idx];
      end
      S_ALLOC: begin
        add_b = ticks_c;
      end
      default: begin
      end
    endcase
  end

  assign sum = add_a + add_b;
  assign hit = active[idx] && (deadline[idx] == count);

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd.operation)
            OP_TICK:  state_next = S_TICK;
            OP_ALLOC: state_next = S_ALLOC;
            default:  state_next = S_DONE;
          endcase
        end
      end
      S_TICK:  state_next = S_SCAN;
      S_SCAN:  if (last) state_next = S_DONE;
      S_ALLOC: if (!active[idx] || last) state_next = S_DONE;
      S_DONE:  if (rsp_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Slot state and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      active  <= '0;
      timeout <= '0;
      idx     <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op_q       <= cmd.operation;
            ticks_q    <= cmd.ticks;
            periodic_q <= cmd.periodic;
            fired      <= '0;
            alloc_fail <= 1'b0;
            idx        <= '0;
            // Apply remove and clear flag at once
            if (slot_ok) begin
              if (cmd.operation == OP_REMOVE) begin
                active[slot_idx]  <= 1'b0;
                timeout[slot_idx] <= 1'b0;
              end else if (cmd.operation == OP_CLEAR) begin
                timeout[slot_idx] <= 1'b0;
              end
            end
          end
        end
        S_TICK: begin
          count <= sum;
        end
        S_SCAN: begin
          // Fire a matching slot and advance a periodic deadline
          if (hit) begin
            timeout[idx] <= 1'b1;
            fired[idx]   <= 1'b1;
            if (period[idx] != '0) begin
              deadline[idx] <= sum;
            end
          end
          idx <= last ? '0 : idx + 1'b1;
        end
        S_ALLOC: begin
          // Take the lowest free slot
          if (!active[idx]) begin
            deadline[idx] <= sum;
            period[idx]   <= periodic_q ? ticks_c : '0;
            timeout[idx]  <= 1'b0;
            active[idx]   <= 1'b1;
          end else if (last) begin
            alloc_fail <= 1'b1;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_DONE: begin
          if (rsp_load) begin
            idx <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Map slots onto the fixed-width vectors
  for (genvar g = 0; g < VEC_W; g++) begin : g_vec
    if (g < NUM_SLOTS) begin : g_on
      assign active_vec[g]  = active[g];
      assign timeout_vec[g] = timeout[g];
      assign fired_vec[g]   = fired[g];
    end else begin : g_off
      assign active_vec[g]  = 1'b0;
      assign timeout_vec[g] = 1'b0;
      assign fired_vec[g]   = 1'b0;
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      if (rsp_load) begin
        rsp.valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.alloc_slot    <= (op_q == OP_ALLOC && !alloc_fail) ? SLOT_W'(idx) : '0;
      rsp.alloc_failed  <= alloc_fail;
      rsp.time_now      <= TIME_W'(count);
      rsp.timeout_flags <= timeout_vec;
      rsp.active_flags  <= active_vec;
      rsp.fired_mask    <= fired_vec;
    end
  end

  // Checks
  `TSB_ASSERT_ALWAYS(a_reset_idle, rst |=> (state == S_IDLE && !rsp.valid), "reset did not idle")
  `TSB_ASSERT(a_tick_count, (accept && cmd.operation == OP_TICK) |-> ##2 (count == COUNT_WIDTH'($past(count, 2) + 1'b1)), "tick did not advance counter")
  `TSB_ASSERT(a_fired_flagged, rsp.valid |-> ((rsp.fired_mask & ~rsp.timeout_flags) == '0), "fired slot without flag")
  `TSB_ASSERT(a_fail_full, (state == S_DONE && alloc_fail) |-> (&active), "allocate failed with a free slot")
  `TSB_ASSERT(a_fired_tick_only, (state == S_DONE && op_q != OP_TICK) |-> (fired == '0), "fired mask outside tick")

endmodule
